/* hdl/awsu_pkg.sv */
`timescale 1ns / 1ps

package awsu_pkg;

  // Grid geometry and stencil reach.
  localparam int GRID_WIDTH = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int RADIUS     = 4;

  localparam int WIN_DEPTH  = 2 * RADIUS * GRID_WIDTH + 1;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int SIDE_DEPTH = RADIUS * GRID_WIDTH;
  localparam int SIDE_AW    = $clog2(SIDE_DEPTH);
  localparam int MID_LAG    = RADIUS * GRID_WIDTH;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int POS_W = 10;

  // Center, then right, left, lower and upper arms of the cross.
  localparam int NUM_TAPS = 4 * RADIUS + 1;
  localparam int TAP_W    = $clog2(NUM_TAPS);

  localparam int NUM_COEF = 5;
  localparam int COEF_AW  = $clog2(NUM_COEF);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_COEFF_CENTER = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_COEFF_ONE    = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_COEFF_TWO    = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_COEFF_THREE  = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_COEFF_FOUR   = CFG_AW'(4);
  localparam logic [CFG_AW-1:0] REG_TIME_STEP    = CFG_AW'(5);
  localparam logic [CFG_AW-1:0] REG_INV_DX_SQ    = CFG_AW'(6);
  localparam logic [CFG_AW-1:0] REG_INV_DZ_SQ    = CFG_AW'(7);

  localparam int ONE_Q16 = 65536;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 56;

  // Divider: 48-bit dividend, 33-bit divisor, one quotient bit per cycle.
  localparam int DIV_N  = 48;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = $clog2(DIV_N + 1);
  localparam logic [DIV_N-1:0] DIV_A_NUM = DIV_N'(64'd1 << 33);

  typedef enum logic [4:0] {
    S_IDLE,
    S_TAP_RD,
    S_TAP_MUL,
    S_TAP_ACC,
    S_LAPX_MUL,
    S_LAPX_ACC,
    S_LAPZ_MUL,
    S_LAPZ_ACC,
    S_DT2_MUL,
    S_DT2_SET,
    S_V2_MUL,
    S_V2_SET,
    S_K_MUL,
    S_K_SET,
    S_DD_MUL,
    S_DD_SET,
    S_DIVA_GO,
    S_DIVA_WAIT,
    S_DIVB_GO,
    S_DIVB_WAIT,
    S_DIVG_GO,
    S_DIVG_WAIT,
    S_NA_MUL,
    S_NA_ACC,
    S_NB_MUL,
    S_NB_ACC,
    S_NG_MUL,
    S_NG_ACC,
    S_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_TAP_RD,
    OP_MUL,
    OP_TAP_ACC,
    OP_LAPX_ACC,
    OP_LAPZ_ACC,
    OP_DT2_SET,
    OP_V2_SET,
    OP_K_SET,
    OP_DD_SET,
    OP_DIV_GO,
    OP_DIV_WAIT,
    OP_NA_ACC,
    OP_NB_ACC,
    OP_NG_ACC,
    OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    MS_TAP,
    MS_LAPX,
    MS_LAPZ,
    MS_DT2,
    MS_V2,
    MS_K,
    MS_DD,
    MS_NA,
    MS_NB,
    MS_NG
  } mul_sel_e;

  typedef enum logic [1:0] {
    DS_A,
    DS_B,
    DS_G
  } div_sel_e;

  typedef struct packed {
    dp_op_e           op;
    mul_sel_e         mul;
    div_sel_e         div;
    logic [TAP_W-1:0] tap;
  } awsu_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } awsu_sts_t;

  typedef struct packed {
    logic [WIN_AW-1:0]  lag;
    logic [COEF_AW-1:0] coef;
    logic               to_x;
    logic               to_z;
  } tap_info_t;

  // Window lag, weight and target sum of one tap of the cross.
  function automatic tap_info_t tap_info(input logic [TAP_W-1:0] tap);
    tap_info_t ti;
    int t;
    int i;
    int lag;
    t = int'(tap);
    ti.to_x = 1'b0;
    ti.to_z = 1'b0;
    if (t == 0) begin
      i = 0;
      lag = MID_LAG;
      ti.to_x = 1'b1;
      ti.to_z = 1'b1;
    end else if (t <= RADIUS) begin
      i = t;
      lag = MID_LAG - i;
      ti.to_x = 1'b1;
    end else if (t <= 2 * RADIUS) begin
      i = t - RADIUS;
      lag = MID_LAG + i;
      ti.to_x = 1'b1;
    end else if (t <= 3 * RADIUS) begin
      i = t - 2 * RADIUS;
      lag = (RADIUS - i) * GRID_WIDTH;
      ti.to_z = 1'b1;
    end else begin
      i = t - 3 * RADIUS;
      lag = (RADIUS + i) * GRID_WIDTH;
      ti.to_z = 1'b1;
    end
    ti.lag  = WIN_AW'(lag);
    ti.coef = COEF_AW'(i);
    return ti;
  endfunction

endpackage

/* hdl/awsu_div.sv */
`timescale 1ns / 1ps

module awsu_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [awsu_pkg::DIV_N-1:0]  dividend_i,
  input  logic [awsu_pkg::DIV_DW-1:0] divisor_i,
  output logic [awsu_pkg::DIV_N-1:0]  quotient_o,
  output logic                       done_o
);
  import awsu_pkg::*;

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW-1:0] rem_q, dsr_q;
  logic [DIV_N-1:0]  quo_q;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  // Restoring division: the dividend shifts out of quo_q as quotient bits shift in.
  assign shifted = {rem_q, quo_q[DIV_N-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = ~diff[DIV_DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_N-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* hdl/awsu_datapath.sv */
`timescale 1ns / 1ps

module awsu_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  awsu_pkg::awsu_cmd_t             cmd_i,
  output awsu_pkg::awsu_sts_t             sts_o,
  input  logic                            frame_start_i,
  input  logic [awsu_pkg::IN_TDATA_W-1:0] in_data_i,
  input  logic                            cfg_we_i,
  input  logic [awsu_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  logic [awsu_pkg::CFG_DW-1:0]     cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [awsu_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import awsu_pkg::*;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 41 + $clog2(2 * RADIUS + 1);
  localparam int LAP_W  = 49;
  localparam int NACC_W = 50;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] coeff_q [NUM_COEF];
  logic [31:0]        dt_q, inv_dx_q, inv_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_COEF; n++) begin
        coeff_q[n] <= '0;
      end
      dt_q     <= '0;
      inv_dx_q <= 32'(ONE_Q16);
      inv_dz_q <= 32'(ONE_Q16);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_COEFF_CENTER: coeff_q[0] <= cfg_wdata_i;
        REG_COEFF_ONE:    coeff_q[1] <= cfg_wdata_i;
        REG_COEFF_TWO:    coeff_q[2] <= cfg_wdata_i;
        REG_COEFF_THREE:  coeff_q[3] <= cfg_wdata_i;
        REG_COEFF_FOUR:   coeff_q[4] <= cfg_wdata_i;
        REG_TIME_STEP:    dt_q       <= cfg_wdata_i;
        REG_INV_DX_SQ:    inv_dx_q   <= cfg_wdata_i;
        REG_INV_DZ_SQ:    inv_dz_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input item fields.
  logic [31:0] cur_in, prev_in, speed_in, damp_in;
  assign cur_in   = in_data_i[31:0];
  assign prev_in  = in_data_i[63:32];
  assign speed_in = in_data_i[95:64];
  assign damp_in  = in_data_i[127:96];

  logic load;
  assign load = (cmd_i.op == OP_LOAD);

  // Grid position of the arriving point.
  logic [ROW_W-1:0] row_q, r_cur;
  logic [COL_W-1:0] col_q, c_cur;
  logic             emit;

  assign r_cur = frame_start_i ? '0 : row_q;
  assign c_cur = frame_start_i ? '0 : col_q;
  assign emit  = (r_cur >= ROW_W'(2 * RADIUS)) && (c_cur >= COL_W'(RADIUS))
              && (c_cur < COL_W'(GRID_WIDTH - RADIUS));

  // Window and delay store pointers.
  logic [WIN_AW-1:0]  head_q, head_nx;
  logic [SIDE_AW-1:0] side_ptr_q, side_nx;

  assign head_nx = (head_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign side_nx = (side_ptr_q == SIDE_AW'(SIDE_DEPTH - 1)) ? '0 : side_ptr_q + 1'b1;

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      head_q      <= '0;
      side_ptr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        head_q     <= head_nx;
        side_ptr_q <= side_nx;
        if (c_cur == COL_W'(GRID_WIDTH - 1)) begin
          col_q <= '0;
          row_q <= (r_cur == ROW_W'(MAX_ROWS - 1)) ? '0 : r_cur + 1'b1;
        end else begin
          col_q <= c_cur + 1'b1;
          row_q <= r_cur;
        end
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window of the current field, a circular store read at one tap per access.
  tap_info_t         ti;
  logic [WIN_AW:0]   lag_diff;
  logic [WIN_AW-1:0] win_raddr;
  logic [31:0]       win_mem [WIN_DEPTH];
  logic [31:0]       win_rd_q;

  assign ti        = tap_info(cmd_i.tap);
  assign lag_diff  = {1'b0, head_q} - {1'b0, ti.lag};
  assign win_raddr = lag_diff[WIN_AW] ? WIN_AW'(lag_diff + (WIN_AW + 1)'(WIN_DEPTH))
                                      : lag_diff[WIN_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (load) begin
      win_mem[head_nx] <= cur_in;
    end
    if (cmd_i.op == OP_TAP_RD) begin
      win_rd_q <= win_mem[win_raddr];
    end
  end

  // Delay store: prev, speed and damping of the point RADIUS rows back.
  logic [95:0] side_mem [SIDE_DEPTH];
  logic [95:0] side_rd_q;
  logic [31:0] old_prev, old_speed, old_damp;

  always_ff @(posedge clk_i) begin
    if (load) begin
      side_rd_q            <= side_mem[side_ptr_q];
      side_mem[side_ptr_q] <= {damp_in, speed_in, prev_in};
    end
  end

  assign old_prev  = side_rd_q[31:0];
  assign old_speed = side_rd_q[63:32];
  assign old_damp  = side_rd_q[95:64];

  // Arithmetic registers.
  logic signed [ACC_W-1:0]  acc_x_q, acc_z_q;
  logic signed [LAP_W-1:0]  lap_acc_q;
  logic signed [31:0]       lap_q, center_q;
  logic [31:0]              dt2_q, v2_q, k_q, dd_q, g_q;
  logic signed [18:0]       a_q, b_q;
  logic signed [NACC_W-1:0] nacc_q;
  logic signed [PROD_W-1:0] prod_q, prod_d, sh24, sh16;
  logic signed [63:0]       sh16_64, acc_x64, acc_z64, lap_sum, nacc64;
  logic signed [MUL_W-1:0]  opa, opb;
  logic [31:0]              satu_sh16;
  logic [POS_W-1:0]         crow_q, ccol_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  assign acc_x64 = {{(64 - ACC_W){acc_x_q[ACC_W-1]}}, acc_x_q};
  assign acc_z64 = {{(64 - ACC_W){acc_z_q[ACC_W-1]}}, acc_z_q};
  assign nacc64  = {{(64 - NACC_W){nacc_q[NACC_W-1]}}, nacc_q};

  // One shared signed multiplier; its product is always registered.
  always_comb begin
    unique case (cmd_i.mul)
      MS_TAP: begin
        opa = {{2{coeff_q[ti.coef][31]}}, coeff_q[ti.coef]};
        opb = {{2{win_rd_q[31]}}, win_rd_q};
      end
      MS_LAPX: begin
        opa = MUL_W'(sat32(acc_x64));
        opb = {2'b00, inv_dx_q};
      end
      MS_LAPZ: begin
        opa = MUL_W'(sat32(acc_z64));
        opb = {2'b00, inv_dz_q};
      end
      MS_DT2: begin
        opa = {2'b00, dt_q};
        opb = {2'b00, dt_q};
      end
      MS_V2: begin
        opa = {2'b00, old_speed};
        opb = {2'b00, old_speed};
      end
      MS_K: begin
        opa = {2'b00, dt2_q};
        opb = {2'b00, v2_q};
      end
      MS_DD: begin
        opa = {2'b00, old_damp};
        opb = {2'b00, dt_q};
      end
      MS_NA: begin
        opa = {{(MUL_W - 19){a_q[18]}}, a_q};
        opb = {{2{center_q[31]}}, center_q};
      end
      MS_NB: begin
        opa = {{(MUL_W - 19){b_q[18]}}, b_q};
        opb = {{2{old_prev[31]}}, old_prev};
      end
      MS_NG: begin
        opa = {2'b00, g_q};
        opb = {{2{lap_q[31]}}, lap_q};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d    = opa * opb;
  assign sh24      = prod_q >>> 24;
  assign sh16      = prod_q >>> 16;
  assign sh16_64   = $signed(sh16[63:0]);
  assign lap_sum   = {{(64 - LAP_W){lap_acc_q[LAP_W-1]}}, lap_acc_q} + sh16_64;
  assign satu_sh16 = (|prod_q[63:48]) ? 32'hFFFF_FFFF : prod_q[47:16];

  // Divider operands: den = 1 + dd in Q16.16.
  logic [DIV_DW-1:0] den, b_mag;
  logic [DIV_N-1:0]  div_num, div_quo;
  logic              div_done, b_neg;
  logic [18:0]       q19;

  assign den   = {1'b0, dd_q} + DIV_DW'(ONE_Q16);
  assign b_neg = dd_q > 32'(ONE_Q16);
  assign b_mag = b_neg ? ({1'b0, dd_q} - DIV_DW'(ONE_Q16))
                       : (DIV_DW'(ONE_Q16) - {1'b0, dd_q});
  assign q19   = div_quo[18:0];

  always_comb begin
    unique case (cmd_i.div)
      DS_A:    div_num = DIV_A_NUM;
      DS_B:    div_num = {b_mag[31:0], 16'h0000};
      DS_G:    div_num = {k_q, 16'h0000};
      default: div_num = '0;
    endcase
  end

  awsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV_GO),
    .dividend_i (div_num),
    .divisor_i  (den),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        acc_x_q <= '0;
        acc_z_q <= '0;
        crow_q  <= POS_W'(r_cur - ROW_W'(RADIUS));
        ccol_q  <= POS_W'(c_cur);
      end
      OP_MUL: begin
        prod_q <= prod_d;
        if (cmd_i.mul == MS_TAP && cmd_i.tap == '0) begin
          center_q <= win_rd_q;
        end
      end
      OP_TAP_ACC: begin
        if (ti.to_x) begin
          acc_x_q <= acc_x_q + $signed(sh24[ACC_W-1:0]);
        end
        if (ti.to_z) begin
          acc_z_q <= acc_z_q + $signed(sh24[ACC_W-1:0]);
        end
      end
      OP_LAPX_ACC: lap_acc_q <= $signed(sh16_64[LAP_W-1:0]);
      OP_LAPZ_ACC: lap_q     <= sat32(lap_sum);
      OP_DT2_SET:  dt2_q     <= satu_sh16;
      OP_V2_SET:   v2_q      <= satu_sh16;
      OP_K_SET:    k_q       <= satu_sh16;
      OP_DD_SET:   dd_q      <= satu_sh16;
      OP_DIV_WAIT: begin
        if (div_done) begin
          unique case (cmd_i.div)
            DS_A:    a_q <= $signed(q19);
            DS_B:    b_q <= b_neg ? -$signed(q19) : $signed(q19);
            DS_G:    g_q <= div_quo[31:0];
            default: ;
          endcase
        end
      end
      OP_NA_ACC: nacc_q <= $signed(sh16_64[NACC_W-1:0]);
      OP_NB_ACC: nacc_q <= nacc_q - $signed(sh16_64[NACC_W-1:0]);
      OP_NG_ACC: nacc_q <= nacc_q + $signed(sh16_64[NACC_W-1:0]);
      OP_OUT: begin
        out_data_q <= {{(OUT_TDATA_W - 32 - 2 * POS_W){1'b0}}, ccol_q, crow_q,
                       sat32(nacc64)};
      end
      default: ;
    endcase
  end

  assign sts_o.emit     = emit;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/awsu_ctrl.sv */
`timescale 1ns / 1ps

module awsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  awsu_pkg::awsu_sts_t sts_i,
  output awsu_pkg::awsu_cmd_t cmd_o
);
  import awsu_pkg::*;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(NUM_TAPS - 1);

  ctrl_state_e      state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    unique case (state_q)
      S_IDLE: begin
        tap_d = '0;
        if (in_valid_i && sts_i.emit) begin
          state_d = S_TAP_RD;
        end
      end
      S_TAP_RD:  state_d = S_TAP_MUL;
      S_TAP_MUL: state_d = S_TAP_ACC;
      S_TAP_ACC: begin
        if (tap_q == TAP_LAST) begin
          state_d = S_LAPX_MUL;
        end else begin
          tap_d   = tap_q + 1'b1;
          state_d = S_TAP_RD;
        end
      end
      S_LAPX_MUL: state_d = S_LAPX_ACC;
      S_LAPX_ACC: state_d = S_LAPZ_MUL;
      S_LAPZ_MUL: state_d = S_LAPZ_ACC;
      S_LAPZ_ACC: state_d = S_DT2_MUL;
      S_DT2_MUL:  state_d = S_DT2_SET;
      S_DT2_SET:  state_d = S_V2_MUL;
      S_V2_MUL:   state_d = S_V2_SET;
      S_V2_SET:   state_d = S_K_MUL;
      S_K_MUL:    state_d = S_K_SET;
      S_K_SET:    state_d = S_DD_MUL;
      S_DD_MUL:   state_d = S_DD_SET;
      S_DD_SET:   state_d = S_DIVA_GO;
      S_DIVA_GO:  state_d = S_DIVA_WAIT;
      S_DIVA_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_DIVB_GO;
        end
      end
      S_DIVB_GO:  state_d = S_DIVB_WAIT;
      S_DIVB_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_DIVG_GO;
        end
      end
      S_DIVG_GO:  state_d = S_DIVG_WAIT;
      S_DIVG_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_NA_MUL;
        end
      end
      S_NA_MUL:   state_d = S_NA_ACC;
      S_NA_ACC:   state_d = S_NB_MUL;
      S_NB_MUL:   state_d = S_NB_ACC;
      S_NB_ACC:   state_d = S_NG_MUL;
      S_NG_MUL:   state_d = S_NG_ACC;
      S_NG_ACC:   state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.mul  = MS_TAP;
    cmd_o.div  = DS_A;
    cmd_o.tap  = tap_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      S_TAP_RD:    cmd_o.op = OP_TAP_RD;
      S_TAP_MUL:   cmd_o.op = OP_MUL;
      S_TAP_ACC:   cmd_o.op = OP_TAP_ACC;
      S_LAPX_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_LAPX;
      end
      S_LAPX_ACC:  cmd_o.op = OP_LAPX_ACC;
      S_LAPZ_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_LAPZ;
      end
      S_LAPZ_ACC:  cmd_o.op = OP_LAPZ_ACC;
      S_DT2_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_DT2;
      end
      S_DT2_SET:   cmd_o.op = OP_DT2_SET;
      S_V2_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_V2;
      end
      S_V2_SET:    cmd_o.op = OP_V2_SET;
      S_K_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_K;
      end
      S_K_SET:     cmd_o.op = OP_K_SET;
      S_DD_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_DD;
      end
      S_DD_SET:    cmd_o.op = OP_DD_SET;
      S_DIVA_GO:   cmd_o.op = OP_DIV_GO;
      S_DIVA_WAIT: cmd_o.op = OP_DIV_WAIT;
      S_DIVB_GO: begin
        cmd_o.op  = OP_DIV_GO;
        cmd_o.div = DS_B;
      end
      S_DIVB_WAIT: begin
        cmd_o.op  = OP_DIV_WAIT;
        cmd_o.div = DS_B;
      end
      S_DIVG_GO: begin
        cmd_o.op  = OP_DIV_GO;
        cmd_o.div = DS_G;
      end
      S_DIVG_WAIT: begin
        cmd_o.op  = OP_DIV_WAIT;
        cmd_o.div = DS_G;
      end
      S_NA_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_NA;
      end
      S_NA_ACC:    cmd_o.op = OP_NA_ACC;
      S_NB_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_NB;
      end
      S_NB_ACC:    cmd_o.op = OP_NB_ACC;
      S_NG_MUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.mul = MS_NG;
      end
      S_NG_ACC:    cmd_o.op = OP_NG_ACC;
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/acoustic_wave_stencil_update.sv */
// Damped 2-D acoustic wave update over a streamed grid, one time step per pass.
// Grid points arrive on the slave stream in row-major order, one point per beat;
// tuser marks the first point of a new time step. Line buffers hold the last
// 2*RADIUS rows of the current field and a delay store holds prev, speed and
// damping of the center row. For each interior center the master stream carries
// one beat with the next wavefield value and its row and column.
// A border point is accepted in the idle state and produces no beat. An interior
// point occupies the block for a read, a multiply and an accumulate per stencil
// tap through the single window read port and the shared multiplier, then the
// laplacian and time factors, then three 48-step divisions for the damping
// factors in the radix-2 divider, then the final multiply-accumulates and the
// output state.
// A finished beat waits in an output register, so the next point is accepted
// while the receiver stalls; the slave stream is held off while an interior
// point is in work and when a second result is ready before the first is taken.
// Reset clears the row and column counters, the store pointers and the output
// valid, and loads the register defaults; the line buffers need no clearing.
// The user must write the configuration port only while the block is idle; nothing enforces it.
`timescale 1ns / 1ps

module acoustic_wave_stencil_update (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cur_value[31:0], prev_value[63:32], wave_speed[95:64], damping[127:96]
  input  logic [awsu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // frame_start
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // next_value[31:0], center_row[41:32], center_col[51:42], zero[55:52]
  output logic [awsu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [awsu_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [awsu_pkg::CFG_DW-1:0]      cfg_wdata_i
);
  import awsu_pkg::*;

  awsu_cmd_t cmd;
  awsu_sts_t sts;

  // The sequencer walks one point through the datapath at a time.
  awsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line buffers, delay store, shared multiplier, divider and output register.
  awsu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_start_i (s_axis_tuser),
    .in_data_i     (s_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

/* verif/acoustic_wave_stencil_update_test.sv */
`timescale 1ns / 1ps

module acoustic_wave_stencil_update_test;
  import awsu_pkg::*;

  // The run sends about 50k points. Even if every one were an interior point,
  // stretched by gaps and stalls, the run would stay well below this limit.
  localparam int CYCLE_LIMIT = 100_000_000;
  localparam int DRAIN_CYCLES = 12 * RADIUS + 200;
  localparam int IDLE_PCT     = 36;
  localparam int NUM_PHASES   = 6;

  // Value styles for the stimulus words.
  typedef enum int {
    VAL_FULL,
    VAL_EXTREME,
    VAL_MODERATE
  } val_style_e;

  typedef struct {
    bit                 frame_start;
    logic signed [31:0] cur;
    logic signed [31:0] prev;
    logic [31:0]        speed;
    logic [31:0]        damp;
  } grid_point_t;

  typedef struct {
    logic signed [31:0] next_val;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
  } wave_update_t;

  // Keeps its own copy of the line buffers, the side store, the position
  // counters and the registers, and predicts the update for every center.
  class wave_update_board;
    logic [31:0]  win_mem[WIN_DEPTH];
    logic [31:0]  side_prev[SIDE_DEPTH];
    logic [31:0]  side_speed[SIDE_DEPTH];
    logic [31:0]  side_damp[SIDE_DEPTH];
    int unsigned  win_head;
    int unsigned  side_ptr;
    int unsigned  row_pos;
    int unsigned  col_pos;
    logic [31:0]  reg_val[8];
    wave_update_t expected_updates[$];
    int           fails;

    function new();
      win_head = 0;
      side_ptr = 0;
      row_pos  = 0;
      col_pos  = 0;
      fails    = 0;
      foreach (reg_val[i]) reg_val[i] = '0;
      reg_val[REG_INV_DX_SQ] = ONE_Q16;
      reg_val[REG_INV_DZ_SQ] = ONE_Q16;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      fails++;
    endtask

    function automatic longint win_tap(int unsigned lag);
      logic signed [31:0] w;
      w = win_mem[(win_head + WIN_DEPTH - lag) % WIN_DEPTH];
      return longint'(w);
    endfunction

    function automatic longint weighted(int i, longint u);
      logic signed [31:0] cw;
      cw = reg_val[i];
      return (longint'(cw) * u) >>> 24;
    endfunction

    function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function automatic longint unsigned satu32(longint unsigned x);
      return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
    endfunction

    // Called for every accepted input beat.
    function void note_point(grid_point_t p);
      int unsigned       r, c, mid;
      longint            center, sx, sz, lap, prv, a, b, g, den, nxt;
      longint unsigned   dt, v, dd, dt2, v2, k;
      logic [31:0]       o_prev, o_speed, o_damp;
      logic signed [31:0] ps;
      wave_update_t      e;
      r = p.frame_start ? 0 : row_pos;
      c = p.frame_start ? 0 : col_pos;

      win_head = (win_head + 1) % WIN_DEPTH;
      win_mem[win_head] = p.cur;

      o_prev  = side_prev[side_ptr];
      o_speed = side_speed[side_ptr];
      o_damp  = side_damp[side_ptr];
      side_prev[side_ptr]  = p.prev;
      side_speed[side_ptr] = p.speed;
      side_damp[side_ptr]  = p.damp;
      side_ptr = (side_ptr + 1) % SIDE_DEPTH;

      if (r >= 2 * RADIUS && c >= RADIUS && c + RADIUS < GRID_WIDTH) begin
        mid    = MID_LAG;
        center = win_tap(mid);
        sx     = weighted(0, center);
        sz     = sx;
        for (int i = 1; i <= RADIUS; i++) begin
          sx += weighted(i, win_tap(mid - i)) + weighted(i, win_tap(mid + i));
          sz += weighted(i, win_tap((RADIUS - i) * GRID_WIDTH))
              + weighted(i, win_tap((RADIUS + i) * GRID_WIDTH));
        end
        sx  = sat32(sx);
        sz  = sat32(sz);
        lap = sat32(((sx * longint'(reg_val[REG_INV_DX_SQ])) >>> 16)
                  + ((sz * longint'(reg_val[REG_INV_DZ_SQ])) >>> 16));

        dt  = reg_val[REG_TIME_STEP];
        v   = o_speed;
        dt2 = satu32((dt * dt) >> 16);
        v2  = satu32((v * v) >> 16);
        k   = satu32((dt2 * v2) >> 16);
        dd  = satu32((longint'(o_damp) * dt) >> 16);
        den = longint'(ONE_Q16) + longint'(dd);

        // Damping factors; signed division truncates toward zero.
        a = (longint'(1) << 33) / den;
        b = ((longint'(ONE_Q16) - longint'(dd)) * ONE_Q16) / den;
        g = (longint'(k) * ONE_Q16) / den;

        ps  = o_prev;
        prv = longint'(ps);
        nxt = sat32(((a * center) >>> 16) - ((b * prv) >>> 16) + ((g * lap) >>> 16));

        e.next_val = nxt[31:0];
        e.row      = POS_W'(r - RADIUS);
        e.col      = POS_W'(c);
        expected_updates.push_back(e);
      end

      c++;
      if (c >= GRID_WIDTH) begin
        c = 0;
        r++;
        if (r >= MAX_ROWS) r = 0;
      end
      row_pos = r % 1024;
      col_pos = c % 1024;
    endfunction

    // Called for every accepted output beat.
    task check_beat(logic [OUT_TDATA_W-1:0] d);
      wave_update_t e;
      if (expected_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", d));
      end else begin
        e = expected_updates.pop_front();
        if (d[31:0] !== e.next_val)
          report_mismatch($sformatf("next_value %h, want %h (row %0d col %0d)",
                                    d[31:0], e.next_val, e.row, e.col));
        if (d[41:32] !== e.row)
          report_mismatch($sformatf("center_row %0d, want %0d", d[41:32], e.row));
        if (d[51:42] !== e.col)
          report_mismatch($sformatf("center_col %0d, want %0d", d[51:42], e.col));
        if (d[55:52] !== 4'b0)
          report_mismatch($sformatf("pad bits %h not zero", d[55:52]));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr_i = '0;
  logic [CFG_DW-1:0]      cfg_wdata_i = '0;

  wave_update_board board;
  bit               no_idle = 1'b0;
  int unsigned      cycle_count = 0;

  acoustic_wave_stencil_update u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side: check each accepted beat, then decide on a stall for the
  // next cycle. Values are sampled before the edge's updates take effect.
  initial begin
    board = new();
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [31:0] pick_word(val_style_e style, bit is_signed);
    logic [31:0] w;
    case (style)
      VAL_EXTREME: begin
        case ($urandom_range(4))
          0: w = 32'h0000_0000;
          1: w = 32'h0000_0001;
          2: w = 32'h7FFF_FFFF;
          3: w = 32'h8000_0000;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
      VAL_MODERATE: begin
        // Around 1.0 in the format of the field, so results rarely saturate.
        if (is_signed) w = $urandom_range(32'h0200_0000) - 32'h0100_0000;
        else w = $urandom_range(32'h0004_0000);
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Send one grid point and wait for the beat to be taken. The valid is
  // lowered only when a gap is inserted, so it never drops and rises in one step.
  task automatic send_point(bit fs, val_style_e style);
    grid_point_t p;
    p.frame_start = fs;
    p.cur   = pick_word(style, 1'b1);
    p.prev  = pick_word(style, 1'b1);
    p.speed = pick_word(style, 1'b0);
    p.damp  = pick_word(style, 1'b0);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fs;
    s_axis_tdata  <= {p.damp, p.speed, p.prev, p.cur};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(p);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.reg_val[idx] = val;
  endtask

  task automatic program_regs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                              logic [31:0] c3, logic [31:0] c4, logic [31:0] dt,
                              logic [31:0] idx2, logic [31:0] idz2);
    write_reg(REG_COEFF_CENTER, c0);
    write_reg(REG_COEFF_ONE, c1);
    write_reg(REG_COEFF_TWO, c2);
    write_reg(REG_COEFF_THREE, c3);
    write_reg(REG_COEFF_FOUR, c4);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_INV_DX_SQ, idx2);
    write_reg(REG_INV_DZ_SQ, idz2);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.expected_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int         extra;
    val_style_e style;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Each phase is one time step: eight rows that only fill the line buffers,
    // then a stretch of row 8 onward where centers get updated. Phase 0 runs
    // on the reset defaults (zero weights, dt of zero), the others on fresh
    // register settings written while the block is idle.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: program_regs(32'hFD33_3333, 32'h0180_0000, 32'hFFC0_0000, 32'h0010_0000,
                        32'hFFFC_0000, 32'h0000_4000, 32'h0001_8000, 32'h0000_C000);
        2: program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        3, 5: program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(32'h0002_0000), $urandom, $urandom);
        default: ;
      endcase

      // Phase 1 runs with no gaps or stalls at all.
      no_idle = (ph == 1);
      // Phase 3 walks all of row 8 and into row 9, so the right border, the
      // row wrap and the left border after it are all reached.
      extra = (ph == 3) ? GRID_WIDTH + 12 : $urandom_range(40, 120);

      for (int n = 0; n < 2 * RADIUS * GRID_WIDTH + extra; n++) begin
        case (ph)
          2, 4: style = ($urandom_range(3) == 0) ? VAL_FULL : VAL_EXTREME;
          1:    style = VAL_MODERATE;
          default: style = val_style_e'($urandom_range(2));
        endcase
        // The first phase starts from the reset counters without the marker;
        // every later phase restarts mid-row with it.
        send_point((n == 0) && (ph != 0), style);
      end
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    if (board.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/awsu_pkg.sv
hdl/awsu_div.sv
hdl/awsu_datapath.sv
hdl/awsu_ctrl.sv
hdl/acoustic_wave_stencil_update.sv
verif/acoustic_wave_stencil_update_test.sv
